### rtl/fevd_pkg.sv
`default_nettype none

package fevd_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int SQ_W      = 31;
    localparam int ENERGY_W  = 43;
    localparam int LEN_W     = 13;
    localparam int THR_W     = 31;
    localparam int RUN_W     = 8;
    localparam int BAR_W     = THR_W + LEN_W;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [LEN_W-1:0] MAX_FRAME     = LEN_W'(4096);
    localparam logic [LEN_W-1:0] LEN_RESET     = LEN_W'(320);
    localparam logic [THR_W-1:0] THR_RESET     = THR_W'(154610);
    localparam logic [RUN_W-1:0] MIN_RUN_RESET = RUN_W'(3);

    typedef enum logic [1:0] {
        REG_FRAME_LENGTH = 2'd0,
        REG_THRESHOLD    = 2'd1,
        REG_MIN_RUN      = 2'd2
    } reg_index_t;

    // one closed frame handed from the accumulator to the judge
    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [LEN_W-1:0]    count;
        logic                last;
    } frame_t;

endpackage

`default_nettype wire

### rtl/frame_energy_voice_detector.sv
// a final sample beat reaches the verdict through the square, frame, bar and verdict output registers
// throughput: one sample beat per cycle, set by the squaring stage and the 43-bit saturating accumulator
// but a beat that closes a frame waits, only while the judge is backed up behind an unclaimed verdict
// reset (rst_n low, async): pipeline, frame, run and detection state cleared,
// registers back to frame length 320, threshold 154610, minimum run 3
`default_nettype none

module frame_energy_voice_detector (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [fevd_pkg::ADDR_W-1:0]          paddr,
    input  logic [fevd_pkg::DATA_W-1:0]          pwdata,
    output logic [fevd_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready,
    // sample beats
    input  logic signed [fevd_pkg::SAMPLE_W-1:0] sample,
    input  logic                                 final_sample,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    // verdict beats
    output logic                                 voice_detected,
    output logic                                 verdict_valid,
    input  logic                                 verdict_stall
);
    import fevd_pkg::*;

    // configuration registers
    logic [LEN_W-1:0]    frame_length_reg;
    logic [THR_W-1:0]    threshold_reg;
    logic [RUN_W-1:0]    min_run_reg;
    logic                cfg_write;
    reg_index_t          reg_index;

    // accumulator to judge
    logic                frame_valid;
    frame_t              frame;
    logic                frame_take;

    // judge stage: energy bar for the closed frame
    logic                bar_valid_reg;
    logic [BAR_W-1:0]    bar_reg;
    logic [ENERGY_W-1:0] bar_energy_reg;
    logic                bar_last_reg;
    logic [BAR_W-1:0]    bar_next;

    // run tracking and verdict output
    logic [RUN_W-1:0]    run_reg;
    logic                flag_reg;
    logic                verdict_valid_reg;
    logic                voice_detected_reg;
    logic [RUN_W-1:0]    need;
    logic                voiced;
    logic [RUN_W-1:0]    run_next;
    logic                flag_next;
    logic                out_free;
    logic                bar_move;
    logic                bar_free;

    // ---------------------------------------------------------------
    // register file, word addressed, one register per 32-bit word
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = reg_index_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= LEN_RESET;
            threshold_reg    <= THR_RESET;
            min_run_reg      <= MIN_RUN_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_FRAME_LENGTH: frame_length_reg <= pwdata[LEN_W-1:0];
                REG_THRESHOLD:    threshold_reg    <= pwdata[THR_W-1:0];
                REG_MIN_RUN:      min_run_reg      <= pwdata[RUN_W-1:0];
                default:          ;  // unmapped word, write dropped
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_FRAME_LENGTH: prdata = {{(DATA_W-LEN_W){1'b0}}, frame_length_reg};
            REG_THRESHOLD:    prdata = {{(DATA_W-THR_W){1'b0}}, threshold_reg};
            REG_MIN_RUN:      prdata = {{(DATA_W-RUN_W){1'b0}}, min_run_reg};
            default:          prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // squaring and per-frame accumulation
    // ---------------------------------------------------------------
    fevd_frame_acc u_frame_acc (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .final_sample (final_sample),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .frame_length (frame_length_reg),
        .frame_valid  (frame_valid),
        .frame        (frame),
        .frame_take   (frame_take)
    );

    // ---------------------------------------------------------------
    // backpressure: only a final frame needs the output register
    // ---------------------------------------------------------------
    assign out_free   = !verdict_valid_reg || !verdict_stall;
    assign bar_move   = bar_valid_reg && (!bar_last_reg || out_free);
    assign bar_free   = !bar_valid_reg || bar_move;
    assign frame_take = frame_valid && bar_free;

    // threshold times sample count, mean-square test without a divide
    assign bar_next = BAR_W'(threshold_reg) * BAR_W'(frame.count);

    // ---------------------------------------------------------------
    // frame verdict and run counter
    // ---------------------------------------------------------------
    assign need      = (min_run_reg == '0) ? RUN_W'(1) : min_run_reg;
    assign voiced    = {{(BAR_W-ENERGY_W){1'b0}}, bar_energy_reg} >= bar_reg;
    assign flag_next = flag_reg || (run_next >= need);

    always_comb
    begin
        if (!voiced)
        begin
            run_next = '0;
        end
        else if (run_reg == {RUN_W{1'b1}})
        begin
            run_next = run_reg;  // saturate long runs
        end
        else
        begin
            run_next = run_reg + RUN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bar_valid_reg     <= 1'b0;
            run_reg           <= '0;
            flag_reg          <= 1'b0;
            verdict_valid_reg <= 1'b0;
        end
        else
        begin
            if (frame_take)
            begin
                bar_valid_reg <= 1'b1;
            end
            else if (bar_move)
            begin
                bar_valid_reg <= 1'b0;
            end

            if (bar_move)
            begin
                if (bar_last_reg)
                begin
                    // end of recording: report and start fresh
                    run_reg  <= '0;
                    flag_reg <= 1'b0;
                end
                else
                begin
                    run_reg  <= run_next;
                    flag_reg <= flag_next;
                end
            end

            if (bar_move && bar_last_reg)
            begin
                verdict_valid_reg <= 1'b1;
            end
            else if (!verdict_stall)
            begin
                verdict_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_take)
        begin
            bar_reg        <= bar_next;
            bar_energy_reg <= frame.energy;
            bar_last_reg   <= frame.last;
        end
        if (bar_move && bar_last_reg)
        begin
            voice_detected_reg <= flag_next;
        end
    end

    assign verdict_valid  = verdict_valid_reg;
    assign voice_detected = voice_detected_reg;

endmodule

`default_nettype wire

### rtl/fevd_frame_acc.sv
`default_nettype none

module fevd_frame_acc (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic signed [fevd_pkg::SAMPLE_W-1:0] sample,
    input  logic                                 final_sample,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  logic [fevd_pkg::LEN_W-1:0]           frame_length,
    output logic                                 frame_valid,
    output fevd_pkg::frame_t                     frame,
    input  logic                                 frame_take
);
    import fevd_pkg::*;

    logic                          sq_valid_reg;
    logic [SQ_W-1:0]               sq_reg;
    logic                          sq_last_reg;
    logic [ENERGY_W-1:0]           energy_reg;
    logic [LEN_W-1:0]              pos_reg;
    logic                          frame_valid_reg;
    frame_t                        frame_reg;

    logic signed [2*SAMPLE_W-1:0]  square;
    logic [SQ_W-1:0]               sq_next;
    logic [LEN_W-1:0]              len_eff;
    logic [ENERGY_W:0]             sum_wide;
    logic [ENERGY_W-1:0]           energy_next;
    logic [LEN_W-1:0]              pos_next;
    logic                          close;
    logic                          frame_free;
    logic                          sq_move;
    logic                          sq_free;
    logic                          accept;

    // square of a 16-bit value never exceeds 2^30
    assign square  = sample * sample;
    assign sq_next = square[SQ_W-1:0];

    always_comb
    begin
        if (frame_length == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (frame_length > MAX_FRAME)
        begin
            len_eff = MAX_FRAME;
        end
        else
        begin
            len_eff = frame_length;
        end
    end

    assign sum_wide    = {1'b0, energy_reg} + {{(ENERGY_W-SQ_W+1){1'b0}}, sq_reg};
    assign energy_next = sum_wide[ENERGY_W] ? {ENERGY_W{1'b1}} : sum_wide[ENERGY_W-1:0];
    assign pos_next    = (pos_reg == {LEN_W{1'b1}}) ? pos_reg : pos_reg + LEN_W'(1);
    assign close       = sq_last_reg || (pos_next >= len_eff);

    // a beat that does not close a frame never waits on the judge
    assign frame_free   = !frame_valid_reg || frame_take;
    assign sq_move      = sq_valid_reg && (!close || frame_free);
    assign sq_free      = !sq_valid_reg || sq_move;
    assign sample_stall = !sq_free;
    assign accept       = sample_valid && sq_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg    <= 1'b0;
            energy_reg      <= '0;
            pos_reg         <= '0;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                sq_valid_reg <= 1'b1;
            end
            else if (sq_move)
            begin
                sq_valid_reg <= 1'b0;
            end

            if (sq_move)
            begin
                if (close)
                begin
                    energy_reg <= '0;
                    pos_reg    <= '0;
                end
                else
                begin
                    energy_reg <= energy_next;
                    pos_reg    <= pos_next;
                end
            end

            if (sq_move && close)
            begin
                frame_valid_reg <= 1'b1;
            end
            else if (frame_take)
            begin
                frame_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sq_reg      <= sq_next;
            sq_last_reg <= final_sample;
        end
        if (sq_move && close)
        begin
            frame_reg.energy <= energy_next;
            frame_reg.count  <= pos_next;
            frame_reg.last   <= sq_last_reg;
        end
    end

    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

endmodule

`default_nettype wire

### test/frame_energy_voice_detector_test.sv
module frame_energy_voice_detector_test;

    timeunit 1ns;
    timeprecision 1ps;

    import fevd_pkg::*;

    // register index past the three real ones, a write there must be dropped
    localparam logic [1:0] IDX_UNUSED   = 2'd3;
    // settle time after the final beat, with margin for the verdict to show
    localparam int         DRAIN_CYCLES = 12;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         QUIET_LIMIT  = 5000;
    localparam int         RAND_BEATS   = 1450;
    localparam int         RAND_VERDICTS = 60;

    typedef enum logic {
        ROW_WRITE,
        ROW_BEAT
    } row_kind_t;

    // one sample beat, optionally with its verdict written out by hand
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] pcm;
        logic                       last_flag;
        logic                       typed;
        logic                       typed_verdict;
    } sample_beat_t;

    typedef struct packed {
        row_kind_t    kind;
        logic [1:0]   reg_idx;
        logic [31:0]  value;
        sample_beat_t beat;
    } stim_row_t;

    // dut ports, all inputs known from time zero
    logic                       clk;
    logic                       rst_n          = 1'b0;
    logic                       psel           = 1'b0;
    logic                       penable        = 1'b0;
    logic                       pwrite         = 1'b0;
    logic [ADDR_W-1:0]          paddr          = '0;
    logic [DATA_W-1:0]          pwdata         = '0;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;
    logic signed [SAMPLE_W-1:0] sample         = '0;
    logic                       final_sample   = 1'b0;
    logic                       sample_valid   = 1'b0;
    logic                       sample_stall;
    logic                       voice_detected;
    logic                       verdict_valid;
    logic                       verdict_stall  = 1'b0;

    // detector mirror: configuration
    logic [LEN_W-1:0]    cfg_frame_len  = LEN_RESET;
    logic [THR_W-1:0]    cfg_ms_thr     = THR_RESET;
    logic [RUN_W-1:0]    cfg_min_streak = MIN_RUN_RESET;
    // detector mirror: recording state
    logic [ENERGY_W-1:0] energy_acc     = '0;
    logic [LEN_W-1:0]    frame_fill     = '0;
    logic [RUN_W-1:0]    voiced_streak  = '0;
    logic                speech_seen    = 1'b0;

    sample_beat_t beat_q[$];
    logic         pending_verdicts[$];
    stim_row_t    stim_rows[$];
    int           beats_open    = 0;
    int           mismatches    = 0;
    int           verdicts_seen = 0;
    int           hold_asks     = 0;
    int           hold_grants   = 0;
    int           quiet_cycles  = 0;

    frame_energy_voice_detector i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .sample         (sample),
        .final_sample   (final_sample),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .voice_detected (voice_detected),
        .verdict_valid  (verdict_valid),
        .verdict_stall  (verdict_stall)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // fold one accepted beat into the mirror, queue the verdict on a final beat
    task automatic advance_detector(input sample_beat_t b);
        logic [SAMPLE_W-1:0]   mag;
        logic [2*SAMPLE_W-1:0] sq;
        logic [ENERGY_W:0]     acc;
        logic [LEN_W-1:0]      len;
        logic [BAR_W-1:0]      bar;
        logic [RUN_W-1:0]      need;
        // magnitude as unsigned, full-scale negative gives 32768
        mag = b.pcm[SAMPLE_W-1] ? -b.pcm : b.pcm;
        sq  = mag * mag;
        // saturating accumulate
        acc = {1'b0, energy_acc} + sq;
        energy_acc = acc[ENERGY_W] ? '1 : acc[ENERGY_W-1:0];
        if (frame_fill != '1)
            frame_fill++;
        // zero length means one, anything past the max frame is clamped
        len = (cfg_frame_len == '0) ? LEN_W'(1)
            : (cfg_frame_len > MAX_FRAME) ? MAX_FRAME : cfg_frame_len;
        // a lowered length closes the frame as soon as the fill reaches it
        if (frame_fill >= len || b.last_flag)
        begin
            bar  = BAR_W'(cfg_ms_thr) * BAR_W'(frame_fill);
            need = (cfg_min_streak == '0) ? RUN_W'(1) : cfg_min_streak;
            if (BAR_W'(energy_acc) >= bar)
            begin
                if (voiced_streak != '1)
                    voiced_streak++;
            end
            else
                voiced_streak = '0;
            if (voiced_streak >= need)
                speech_seen = 1'b1;
            energy_acc = '0;
            frame_fill = '0;
        end
        if (b.last_flag)
        begin
            pending_verdicts.push_back(b.typed ? b.typed_verdict : speech_seen);
            energy_acc    = '0;
            frame_fill    = '0;
            voiced_streak = '0;
            speech_seen   = 1'b0;
        end
    endtask

    // setup cycle then access cycle, mirror follows once the write lands
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FRAME_LENGTH: cfg_frame_len  = value[LEN_W-1:0];
            REG_THRESHOLD:    cfg_ms_thr     = value[THR_W-1:0];
            REG_MIN_RUN:      cfg_min_streak = value[RUN_W-1:0];
            default:          ;
        endcase
    endtask

    task automatic push_beat(input sample_beat_t b);
        beat_q.push_back(b);
        beats_open++;
    endtask

    // every beat taken, every verdict claimed, then let the pipeline settle
    task automatic wait_for_idle();
        @(posedge clk);
        while (beats_open != 0 || pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic add_write(input logic [1:0] idx, input logic [31:0] value);
        stim_row_t row;
        row         = '0;
        row.kind    = ROW_WRITE;
        row.reg_idx = idx;
        row.value   = value;
        stim_rows.push_back(row);
    endtask

    task automatic add_beat(input logic signed [SAMPLE_W-1:0] pcm, input logic last_flag,
                            input logic typed, input logic typed_verdict);
        stim_row_t row;
        row                    = '0;
        row.kind               = ROW_BEAT;
        row.beat.pcm           = pcm;
        row.beat.last_flag     = last_flag;
        row.beat.typed         = typed;
        row.beat.typed_verdict = typed_verdict;
        stim_rows.push_back(row);
    endtask

    // sample sender: bursts of random length with random gaps between them
    always @(posedge clk)
    begin : sample_sender
        sample_beat_t beat_now;
        int           burst_left;
        int           gap_left;
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
            begin
                advance_detector(beat_now);
                beats_open--;
            end
            if (!sample_valid || !sample_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    sample_valid <= 1'b0;
                end
                else if (beat_q.size() > 0)
                begin
                    beat_now = beat_q.pop_front();
                    sample       <= beat_now.pcm;
                    final_sample <= beat_now.last_flag;
                    sample_valid <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        // now and then a long stretch with no gaps at all
                        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                                 : $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // verdict receiver: checks each claimed beat, stalls on its own on/off pattern,
    // and serves long hold-offs on request so the block backs up into its input
    always @(posedge clk)
    begin : verdict_receiver
        logic want;
        bit   rx_busy;
        int   rx_left;
        int   hold_left;
        if (verdict_valid && !verdict_stall)
        begin
            verdicts_seen++;
            if (pending_verdicts.size() == 0)
                report_mismatch($sformatf("verdict %0d = %b with none outstanding",
                                          verdicts_seen, voice_detected));
            else
            begin
                want = pending_verdicts.pop_front();
                if (voice_detected !== want)
                    report_mismatch($sformatf("verdict %0d: voice_detected %b, want %b",
                                              verdicts_seen, voice_detected, want));
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            verdict_stall <= 1'b1;
        end
        else if (hold_grants != hold_asks)
        begin
            hold_grants++;
            hold_left = HOLD_CYCLES - 1;
            verdict_stall <= 1'b1;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_busy = !rx_busy;
                // short stalls, mostly short free runs, sometimes a long free run
                rx_left = rx_busy ? $urandom_range(1, 7)
                        : ($urandom_range(0, 4) == 0) ? $urandom_range(20, 120)
                        : $urandom_range(0, 10);
            end
            else
                rx_left--;
            verdict_stall <= rx_busy;
        end
    end

    // nothing taken on either side for too long means the block is hung
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && !sample_stall) || (verdict_valid && !verdict_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("FAIL frame_energy_voice_detector");
                $finish;
            end
        end
    end

    initial
    begin
        sample_beat_t b;
        int           phase_no;
        int           rand_beats;
        int           rand_verdicts;
        int           phase_beats;
        int           target;
        int           rec_lo;
        int           rec_hi;
        int           rec_len;
        int           len_eff;
        int           amp;
        int           mag;
        int           style;
        bit           cut;
        bit           only_loud;
        logic [31:0]  set_len;
        logic [31:0]  set_thr;
        logic [31:0]  set_min;

        // directed rows: reset settings first, then the corners
        add_beat(16'sd0, 1'b1, 1'b1, 1'b0);          // silence under reset settings
        add_beat(-16'sd32768, 1'b1, 1'b1, 1'b0);     // one loud frame, run of 3 needed
        add_write(REG_MIN_RUN, 32'd0);               // zero min run acts as one
        add_beat(-16'sd32768, 1'b1, 1'b1, 1'b1);
        add_beat(16'sd32767, 1'b1, 1'b1, 1'b1);
        add_beat(16'sd0, 1'b1, 1'b1, 1'b0);
        add_write(REG_THRESHOLD, 32'd0);             // zero threshold voices silence
        add_beat(16'sd0, 1'b1, 1'b1, 1'b1);
        add_write(REG_FRAME_LENGTH, 32'd0);          // zero length acts as one
        add_write(REG_THRESHOLD, 32'h7FFF_FFFF);     // top threshold, nothing passes
        add_write(REG_MIN_RUN, 32'd255);
        add_beat(16'sd32767, 1'b0, 1'b0, 1'b0);
        add_beat(-16'sd32768, 1'b1, 1'b1, 1'b0);
        add_write(IDX_UNUSED, 32'hFFFF_FFFF);        // dropped write
        add_write(REG_FRAME_LENGTH, 32'hFFFF_FFFF);  // masked to 8191, clamped to max frame
        add_write(REG_THRESHOLD, 32'd1);
        add_write(REG_MIN_RUN, 32'd1);
        add_beat(16'sd1, 1'b0, 1'b0, 1'b0);
        add_beat(-16'sd1, 1'b0, 1'b0, 1'b0);
        add_beat(16'sd0, 1'b0, 1'b0, 1'b0);
        add_beat(16'sd2, 1'b1, 1'b0, 1'b0);
        add_write(REG_FRAME_LENGTH, 32'd4);
        add_beat(16'sd100, 1'b0, 1'b0, 1'b0);
        add_beat(-16'sd100, 1'b0, 1'b0, 1'b0);
        add_beat(16'sd100, 1'b0, 1'b0, 1'b0);
        add_write(REG_FRAME_LENGTH, 32'd2);          // lowered below the current fill
        add_beat(16'sd0, 1'b1, 1'b0, 1'b0);
        add_write(REG_FRAME_LENGTH, 32'd1);
        add_write(REG_THRESHOLD, 32'd1073741824);    // full-scale negative hits it exactly
        add_beat(-16'sd32768, 1'b1, 1'b1, 1'b1);
        add_beat(16'sd32767, 1'b1, 1'b1, 1'b0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[r])
        begin
            if (stim_rows[r].kind == ROW_WRITE)
            begin
                wait_for_idle();
                write_register(stim_rows[r].reg_idx, stim_rows[r].value);
            end
            else
                push_beat(stim_rows[r].beat);
        end

        // random phases: new settings each phase, recordings of random shape;
        // some phases end mid-recording so the next settings land mid-frame
        phase_no      = 0;
        rand_beats    = 0;
        rand_verdicts = 0;
        while (rand_beats < RAND_BEATS || rand_verdicts < RAND_VERDICTS)
        begin
            target    = 50;
            rec_lo    = 1;
            rec_hi    = 0;
            only_loud = 1'b0;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: set_len = $urandom_range(1, 12);
                7, 8:                set_len = $urandom_range(13, 64);
                default:             set_len = $urandom_range(0, 8191);
            endcase
            case ($urandom_range(0, 4))
                0:       set_thr = 32'd0;
                1:       set_thr = $urandom_range(0, 1 << 20);
                2:       set_thr = 32'd154610;
                3:       set_thr = $urandom & 32'h7FFF_FFFF;
                default: set_thr = $urandom_range(100000, 1 << 24);
            endcase
            set_min = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 4);
            case (phase_no)
                0:
                begin
                    set_len = 32'd0;
                    set_thr = 32'd0;
                    set_min = 32'd0;
                end
                1:
                begin
                    // length past the max frame, taken as the max frame
                    set_len = 32'd8191;
                    set_thr = 32'd154610;
                    set_min = 32'd1;
                end
                2:
                begin
                    set_len = 32'd4096;
                    set_thr = 32'd1073741824;
                    set_min = 32'd1;
                end
                3, 10:
                begin
                    // receiver holds off while short recordings keep coming
                    set_len = $urandom_range(1, 3);
                    rec_hi  = 3;
                    target  = 80;
                end
                4:
                begin
                    // loud single-sample frames past 255 so the run counter saturates
                    set_len   = 32'd1;
                    set_thr   = 32'd1;
                    set_min   = 32'd255;
                    rec_lo    = 256;
                    rec_hi    = 300;
                    target    = 1;
                    only_loud = 1'b1;
                end
                5:
                begin
                    set_len = 32'd1;
                    set_thr = 32'h7FFF_FFFF;
                    set_min = 32'd255;
                end
                default: ;
            endcase

            wait_for_idle();
            write_register(REG_FRAME_LENGTH, set_len);
            write_register(REG_THRESHOLD, set_thr);
            write_register(REG_MIN_RUN, set_min);
            if ($urandom_range(0, 7) == 0)
                write_register(IDX_UNUSED, $urandom);
            // hold-off starts together with the short recordings of this phase
            if (phase_no == 3 || phase_no == 10)
                hold_asks++;

            len_eff = (set_len[LEN_W-1:0] == 0) ? 1
                    : (set_len[LEN_W-1:0] > MAX_FRAME) ? int'(MAX_FRAME) : int'(set_len[LEN_W-1:0]);
            if (rec_hi == 0)
                rec_hi = (len_eff * 5 > 60) ? 60 : len_eff * 5;
            // magnitude whose square sits right at the threshold
            amp = int'($sqrt(real'(set_thr[THR_W-1:0])));
            if (amp > 32767)
                amp = 32767;

            phase_beats = 0;
            style       = 1;
            while (phase_beats < target)
            begin
                rec_len = $urandom_range(rec_lo, rec_hi);
                cut     = (phase_beats + rec_len >= target) && ($urandom_range(0, 3) == 0);
                for (int k = 0; k < rec_len; k++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        style = $urandom_range(0, 3);
                    if (only_loud)
                        style = 2;
                    case (style)
                        0:       mag = $urandom_range(0, amp / 2);
                        1:       mag = amp - amp / 8 + $urandom_range(0, amp / 4 + 1);
                        2:       mag = $urandom_range(amp, 32767);
                        default: mag = -1;
                    endcase
                    if (mag > 32767)
                        mag = 32767;
                    if (mag >= 0)
                        b.pcm = $urandom_range(0, 1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
                    else if ($urandom_range(0, 7) == 0)
                        b.pcm = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
                    else
                        b.pcm = SAMPLE_W'($urandom);
                    b.last_flag     = (k == rec_len - 1) && !cut;
                    b.typed         = 1'b0;
                    b.typed_verdict = 1'b0;
                    push_beat(b);
                end
                phase_beats += rec_len;
                rand_beats  += rec_len;
                if (!cut)
                    rand_verdicts++;
            end
            phase_no++;
        end

        wait_for_idle();
        if (mismatches == 0)
            $display("PASS frame_energy_voice_detector");
        else
            $display("FAIL frame_energy_voice_detector");
        $finish;
    end

endmodule

### files.f
rtl/fevd_pkg.sv
rtl/fevd_frame_acc.sv
rtl/frame_energy_voice_detector.sv
test/frame_energy_voice_detector_test.sv
